FILE: rtl/core/sui_pkg.sv
// package for the sorted unique integer list
// sizes, action and status codes, and the control and flag types shared by the cell row
// no dependencies
`default_nettype none

package sui_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned VW = 32;
  localparam int unsigned IW = 4;
  localparam int unsigned FW = 5;
  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_APPEND,
    ACT_READ,
    ACT_CLEAR
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE,
    STS_DUP,
    STS_FULL,
    STS_RANGE
  } status_e;

  typedef struct packed {
    logic live;
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic eq;
  } cell_flag_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_unique_int_list.sv
// top level of the sorted unique integer list: control sequencer and a row of sui_cell
// depends on sui_pkg and sui_cell
//
//   channel   direction  tuser            tdata
//   s_axis    in         action           value, index
//   m_axis    out        status           count, read_value, position
//
// an insert scans the cell row between accept and result until it reaches p, the slot found
// (at most the entry count): a scan token walks the cell row one cell per cycle
// append, read and clear go to the final step at once; one word is in work at a time
// the result register lets the next word be accepted while a result waits
// a stalled result holds the sequencer in its final step; reset empties the list
`default_nettype none

module sorted_unique_int_list (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [sui_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // value, index
  input  wire logic [1:0]                           s_axis_tuser,  // action
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic [sui_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,  // count, read_value, position
  output logic [1:0]                                m_axis_tuser   // status
);
  import sui_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e        state_q, state_d;
  action_e       act_q, act_d;
  logic [VW-1:0] val_q, val_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic          dup_q, dup_d;
  logic          start_q, start_d;
  logic          m_valid_q, m_valid_d;

  status_e       res_status;
  logic [CW-1:0] res_count;
  logic [VW-1:0] res_rdv;
  logic [FW-1:0] res_pos;
  status_e       status_q;
  logic [FW-1:0] ocount_q;
  logic [VW-1:0] rdv_q;
  logic [FW-1:0] opos_q;

  logic          s_fire;
  logic          fin;
  logic          full;
  logic          do_ins;
  logic          do_app;
  logic          hit_any;
  logic          eq_any;
  logic [AW+IW-1:0] idx_ext;
  logic [AW-1:0] rd_addr;
  logic          in_range;

  logic [VW-1:0] entry_v [DEPTH];
  logic [DEPTH:0] tok_v;
  cell_ctl_t     ctl_v   [DEPTH];
  cell_flag_t    flag_v  [DEPTH];
  logic [DEPTH-1:0] hit_v;
  logic [DEPTH-1:0] eq_v;

  assign tok_v[0] = start_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    always_comb begin
      ctl_v[k].live  = CW'(k) < count_q;
      ctl_v[k].shift = fin & do_ins & (CW'(k) > pos_q);
      ctl_v[k].load  = fin & ((do_ins & (CW'(k) == pos_q)) | (do_app & (CW'(k) == count_q)));
    end
    assign hit_v[k] = flag_v[k].hit;
    assign eq_v[k]  = flag_v[k].eq;

    sui_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .value_i (val_q),
      .scan_i  (state_q == S_SCAN),
      .ctl_i   (ctl_v[k]),
      .tok_i   (tok_v[k]),
      .left_i  ((k == 0) ? val_q : entry_v[(k == 0) ? 0 : k - 1]),
      .entry_o (entry_v[k]),
      .tok_o   (tok_v[k+1]),
      .flag_o  (flag_v[k])
    );
  end

  assign hit_any = |hit_v;
  assign eq_any  = |eq_v;

  assign s_axis_tready = state_q == S_IDLE;
  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign fin           = (state_q == S_FINISH) & (~m_valid_q | m_axis_tready);
  assign full          = count_q == CW'(DEPTH);
  assign do_ins        = (act_q == ACT_INSERT) & ~dup_q & ~full;
  assign do_app        = (act_q == ACT_APPEND) & ~full;
  assign idx_ext       = (AW+IW)'(idx_q);
  assign rd_addr       = idx_ext[AW-1:0];
  assign in_range      = idx_ext < (AW+IW)'(count_q);

  // result of the word in its final step
  always_comb begin
    res_status = STS_DONE;
    res_count  = count_q;
    res_rdv    = '0;
    res_pos    = '0;
    case (act_q)
      ACT_INSERT: begin
        if (dup_q) begin
          res_status = STS_DUP;
          res_pos    = FW'(pos_q);
        end else if (full) begin
          res_status = STS_FULL;
        end else begin
          res_pos   = FW'(pos_q);
          res_count = count_q + CW'(1);
        end
      end
      ACT_APPEND: begin
        if (full) begin
          res_status = STS_FULL;
        end else begin
          res_pos   = FW'(count_q);
          res_count = count_q + CW'(1);
        end
      end
      ACT_READ: begin
        if (in_range) begin
          res_rdv = entry_v[rd_addr];
          res_pos = FW'(idx_q);
        end else begin
          res_status = STS_RANGE;
        end
      end
      ACT_CLEAR: begin
        res_count = '0;
      end
      default: begin
        res_status = STS_DONE;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    val_d     = val_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    count_d   = count_q;
    dup_d     = dup_q;
    start_d   = 1'b0;
    m_valid_d = m_valid_q & ~m_axis_tready;
    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          act_d = action_e'(s_axis_tuser);
          val_d = s_axis_tdata[VW-1:0];
          idx_d = s_axis_tdata[VW+IW-1:VW];
          pos_d = '0;
          dup_d = 1'b0;
          if (action_e'(s_axis_tuser) == ACT_INSERT) begin
            start_d = 1'b1;
            state_d = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        if (hit_any) begin
          dup_d   = eq_any;
          state_d = S_FINISH;
        end else if (pos_q == count_q) begin
          state_d = S_FINISH;
        end else begin
          pos_d = pos_q + CW'(1);
        end
      end
      S_FINISH: begin
        if (fin) begin
          count_d   = res_count;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      start_q   <= 1'b0;
      m_valid_q <= 1'b0;
      dup_q     <= 1'b0;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      start_q   <= start_d;
      m_valid_q <= m_valid_d;
      dup_q     <= dup_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    val_q <= val_d;
    idx_q <= idx_d;
    if (fin) begin
      status_q <= res_status;
      ocount_q <= FW'(res_count);
      rdv_q    <= res_rdv;
      opos_q   <= res_pos;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - FW - VW - FW)'(0), opos_q, rdv_q, ocount_q};

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  a_single_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_v))
    else $error("more than one cell hit");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> pos_q <= count_q)
    else $error("scan position past entry count");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside final step");

  a_no_token_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> $countones(tok_v) == 0)
    else $error("scan token left while idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/sui_cell.sv
// one cell of the list row: holds one entry and a scan token
// depends on sui_pkg
`default_nettype none

module sui_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [sui_pkg::VW-1:0]  value_i,
  input  wire logic                    scan_i,
  input  wire sui_pkg::cell_ctl_t      ctl_i,
  input  wire logic                    tok_i,
  input  wire logic [sui_pkg::VW-1:0]  left_i,
  output logic [sui_pkg::VW-1:0]       entry_o,
  output logic                         tok_o,
  output sui_pkg::cell_flag_t          flag_o
);
  import sui_pkg::*;

  logic [VW-1:0] entry_q, entry_d;
  logic          tok_q, tok_d;
  logic          ge;
  logic          eq;
  logic          hit;

  always_comb begin
    ge      = $signed(entry_q) >= $signed(value_i);
    eq      = entry_q == value_i;
    hit     = tok_i & ctl_i.live & ge;
    tok_d   = scan_i & tok_i & ~hit;
    entry_d = entry_q;
    if (ctl_i.load) begin
      entry_d = value_i;
    end else if (ctl_i.shift) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign entry_o    = entry_q;
  assign tok_o      = tok_q;
  assign flag_o.hit = hit;
  assign flag_o.eq  = hit & eq;

endmodule

`default_nettype wire

FILE: verif/tb_sorted_unique_int_list.sv
// testbench for sorted_unique_int_list: directed and random insert, append, read and clear words
// predicts every result from its own copy of the list and checks it field by field
// depends on sui_pkg and the sorted_unique_int_list rtl
`default_nettype none

module tb_sorted_unique_int_list;
  import sui_pkg::*;

  typedef struct {
    status_e               status;
    logic [FW-1:0]         count;
    logic signed [VW-1:0]  read_value;
    logic [FW-1:0]         position;
  } list_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [1:0]             s_tuser = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;

  logic signed [VW-1:0] set_slots [DEPTH];
  int                   set_size = 0;
  list_result_t         pending_results [$];

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int words_sent = 0;
  int err_cnt = 0;

  sorted_unique_int_list i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // value, index
    .s_axis_tuser  (s_tuser),   // action
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // count, read_value, position
    .m_axis_tuser  (m_tuser)    // status
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // list predictor: updates the shadow list and queues the expected result
  function automatic void apply_list_op(action_e act, logic signed [VW-1:0] val,
                                        logic [IW-1:0] idx);
    list_result_t res;
    int i;
    int slot;
    bit dup;
    bit found;
    res.status = STS_DONE;
    res.read_value = '0;
    slot = 0;
    case (act)
      ACT_INSERT: begin
        slot = set_size;
        dup = 1'b0;
        found = 1'b0;
        for (i = 0; i < set_size; i++) begin
          if (!found) begin
            if (set_slots[i] == val) begin
              dup = 1'b1;
              found = 1'b1;
              slot = i;
            end else if (set_slots[i] > val) begin
              found = 1'b1;
              slot = i;
            end
          end
        end
        if (dup) begin
          res.status = STS_DUP;
        end else if (set_size >= DEPTH) begin
          res.status = STS_FULL;
          slot = 0;
        end else begin
          for (i = set_size; i > slot; i--) set_slots[i] = set_slots[i-1];
          set_slots[slot] = val;
          set_size++;
        end
      end
      ACT_APPEND: begin
        if (set_size >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          slot = set_size;
          set_slots[set_size] = val;
          set_size++;
        end
      end
      ACT_READ: begin
        if (int'(idx) < set_size) begin
          res.read_value = set_slots[idx];
          slot = idx;
        end else begin
          res.status = STS_RANGE;
        end
      end
      default: begin
        set_size = 0;
      end
    endcase
    res.count = set_size[FW-1:0];
    res.position = slot[FW-1:0];
    pending_results.push_back(res);
  endfunction

  function automatic void compare_field(string fname, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // result checker and sink stall generator
  initial begin
    list_result_t exp_r;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, got tdata %0h tuser %0h",
                   $time, m_tdata, m_tuser);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          compare_field("status", 32'(exp_r.status), 32'(m_tuser));
          compare_field("count", 32'(exp_r.count), 32'(m_tdata[FW-1:0]));
          compare_field("read_value", exp_r.read_value, m_tdata[FW+VW-1:FW]);
          compare_field("position", 32'(exp_r.position), 32'(m_tdata[2*FW+VW-1:FW+VW]));
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_word(action_e act, logic signed [VW-1:0] val, logic [IW-1:0] idx);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, idx, val};
    s_tuser  <= act;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_list_op(act, val, idx);
    words_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    int r;
    logic signed [VW-1:0] v;
    r = $urandom_range(99);
    if (r < 35) begin
      v = $signed($urandom_range(40)) - 20;
    end else if (r < 65) begin
      v = $urandom;
    end else if (r < 80) begin
      case ($urandom_range(5))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = 32'sh0000_0000;
        3: v = -32'sd1;
        4: v = 32'sh8000_0001;
        default: v = 32'sh7fff_fffe;
      endcase
    end else if (set_size > 0) begin
      v = set_slots[$urandom_range(set_size - 1)];
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic test_edge_values();
    send_word(ACT_READ, 32'sd0, 4'd0);
    send_word(ACT_INSERT, 32'sd0, 4'd0);
    send_word(ACT_INSERT, 32'sh8000_0000, 4'd15);
    send_word(ACT_INSERT, 32'sh7fff_ffff, 4'd0);
    send_word(ACT_INSERT, 32'sd0, 4'd0);
    send_word(ACT_INSERT, -32'sd1, 4'd0);
    send_word(ACT_INSERT, 32'sh7fff_ffff, 4'd0);
    send_word(ACT_INSERT, 32'sh8000_0000, 4'd0);
    send_word(ACT_READ, 32'sd0, 4'd0);
    send_word(ACT_READ, 32'sd0, 4'd3);
    send_word(ACT_READ, 32'sd0, 4'd4);
    send_word(ACT_READ, 32'sd0, 4'd15);
    send_word(ACT_APPEND, 32'sd5, 4'd0);
    send_word(ACT_INSERT, 32'sd3, 4'd0);
    send_word(ACT_READ, 32'shffff_ffff, 4'd5);
    send_word(ACT_CLEAR, 32'sh1234_5678, 4'd9);
    send_word(ACT_READ, 32'sd0, 4'd0);
  endtask

  task automatic test_full_list();
    int i;
    send_word(ACT_CLEAR, 32'sd0, 4'd0);
    for (i = 0; i < DEPTH; i++) send_word(ACT_INSERT, 32'(i * 3 - 20), 4'd0);
    send_word(ACT_INSERT, 32'sd1, 4'd0);
    send_word(ACT_INSERT, -32'sd20, 4'd0);
    send_word(ACT_INSERT, 32'sd25, 4'd0);
    send_word(ACT_APPEND, 32'sd99, 4'd0);
    send_word(ACT_READ, 32'sd0, 4'd15);
    send_word(ACT_CLEAR, 32'sd0, 4'd0);
  endtask

  // clear, fill mostly by sorted inserts, then read back
  task automatic test_sorted_fill(int n);
    int start;
    int len;
    int r;
    start = words_sent;
    while (words_sent - start < n) begin
      send_word(ACT_CLEAR, $urandom, 4'($urandom_range(15)));
      len = $urandom_range(26, 4);
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 75) send_word(ACT_INSERT, pick_value(), 4'($urandom_range(15)));
        else if (r < 85) send_word(ACT_APPEND, pick_value(), 4'($urandom_range(15)));
        else send_word(ACT_READ, $urandom, 4'($urandom_range(15)));
      end
      repeat ($urandom_range(4, 1)) send_word(ACT_READ, $urandom, 4'($urandom_range(15)));
    end
  endtask

  // any action with any content
  task automatic test_mixed_noise(int n);
    repeat (n) send_word(action_e'($urandom_range(3)), pick_value(), 4'($urandom_range(15)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_values();
    test_full_list();
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 68; end
        default: begin sender_idle_pct = 16; sink_stall_pct = 16; end
      endcase
      test_sorted_fill(140);
      test_mixed_noise(55);
      drain_results();
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
